[design/rfc_pkg.sv]
// Shared types and constants for the response frame checker.
`default_nettype none
package rfc_pkg;

  localparam int unsigned BufferDepthDefault = 1024;
  localparam int unsigned IndexSpan          = 1024;  // 10-bit index field
  localparam int unsigned QueueDepthDefault  = 4;
  localparam logic [10:0] CapacityReset      = 11'd1024;

  localparam logic [7:0] Sw1Ok     = 8'h90;
  localparam logic [7:0] Sw2Ok     = 8'h00;
  localparam logic [7:0] Sw1Retry  = 8'h6C;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_CSUM   = 3'd1,
    ST_DETAIL = 3'd2,
    ST_SW     = 3'd3,
    ST_LEN    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_DETAIL = 2'd2
  } cmd_op_e;

  // One queued job for the back end.
  typedef struct packed {
    cmd_op_e     op;
    logic [9:0]  index;
    logic [7:0]  data;
    status_e     status;
    logic [10:0] out_len;
    logic [15:0] sw;
  } cmd_t;

endpackage
`default_nettype wire

[design/rfc_front.sv]
// Front end: deframing state machine, turns received items into queued jobs.
`default_nettype none
module rfc_front #(
  parameter int unsigned BUFFER_DEPTH = rfc_pkg::BufferDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          action_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic [10:0]   capacity_i,
  output logic               push_o,
  output rfc_pkg::cmd_t      cmd_o
);

  localparam logic [10:0] CapLimit =
    (BUFFER_DEPTH < rfc_pkg::IndexSpan) ? 11'(BUFFER_DEPTH) : 11'(rfc_pkg::IndexSpan);

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LEN_HI  = 7'b0000010,
    PH_LEN_LO  = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_SW1     = 7'b0010000,
    PH_SW2     = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] remaining_q, remaining_d;
  logic [10:0] stored_q, stored_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  sw1_q, sw1_d;
  logic [7:0]  sw2_q, sw2_d;

  logic [10:0] cap_eff;
  logic [15:0] len;

  assign cap_eff = (capacity_i < CapLimit) ? capacity_i : CapLimit;
  assign len     = {len_hi_q, rx_byte_i};

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    remaining_d = remaining_q;
    stored_d    = stored_q;
    xor_d       = xor_q;
    sw1_d       = sw1_q;
    sw2_d       = sw2_q;
    push_o      = 1'b0;
    cmd_o       = '{op: rfc_pkg::CMD_STATUS, index: '0, data: '0,
                    status: rfc_pkg::ST_OK, out_len: '0, sw: '0};
    if (accept_i) begin
      if (!action_i) begin
        // new frame: drop whatever was open
        phase_d     = PH_LEN_HI;
        len_hi_d    = '0;
        remaining_d = '0;
        stored_d    = '0;
        xor_d       = '0;
        sw1_d       = '0;
        sw2_d       = '0;
      end else begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_LEN_HI: begin
            len_hi_d = rx_byte_i;
            xor_d    = xor_q ^ rx_byte_i;
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            xor_d = xor_q ^ rx_byte_i;
            if (len < 16'd2) begin
              phase_d       = PH_IDLE;
              push_o        = 1'b1;
              cmd_o.status  = rfc_pkg::ST_LEN;
            end else begin
              remaining_d = len - 16'd2;
              phase_d     = (len != 16'd2) ? PH_PAYLOAD : PH_SW1;
            end
          end
          PH_PAYLOAD: begin
            xor_d = xor_q ^ rx_byte_i;
            if (stored_q < cap_eff) begin
              push_o      = 1'b1;
              cmd_o.op    = rfc_pkg::CMD_WRITE;
              cmd_o.index = stored_q[9:0];
              cmd_o.data  = rx_byte_i;
              stored_d    = stored_q + 11'd1;
            end
            remaining_d = remaining_q - 16'd1;
            if (remaining_q == 16'd1) begin
              phase_d = PH_SW1;
            end
          end
          PH_SW1: begin
            sw1_d   = rx_byte_i;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_SW2;
          end
          PH_SW2: begin
            sw2_d   = rx_byte_i;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_CHECK;
          end
          PH_CHECK: begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
            if (xor_q != rx_byte_i) begin
              cmd_o.status  = rfc_pkg::ST_CSUM;
              cmd_o.out_len = stored_q;
            end else if (sw1_q == rfc_pkg::Sw1Ok && sw2_q == rfc_pkg::Sw2Ok) begin
              cmd_o.status  = rfc_pkg::ST_OK;
              cmd_o.out_len = stored_q;
              cmd_o.sw      = {sw1_q, sw2_q};
            end else if (sw1_q == rfc_pkg::Sw1Retry || sw1_q == rfc_pkg::Sw1Ok) begin
              // SW2 goes to index 0, then the status item
              cmd_o.op      = rfc_pkg::CMD_DETAIL;
              cmd_o.data    = sw2_q;
              cmd_o.status  = rfc_pkg::ST_DETAIL;
              cmd_o.out_len = 11'd1;
              cmd_o.sw      = {sw1_q, sw2_q};
            end else begin
              cmd_o.status  = rfc_pkg::ST_SW;
              cmd_o.out_len = stored_q;
              cmd_o.sw      = {sw1_q, sw2_q};
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      len_hi_q    <= '0;
      remaining_q <= '0;
      stored_q    <= '0;
      xor_q       <= '0;
      sw1_q       <= '0;
      sw2_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      remaining_q <= remaining_d;
      stored_q    <= stored_d;
      xor_q       <= xor_d;
      sw1_q       <= sw1_d;
      sw2_q       <= sw2_d;
    end
  end

endmodule
`default_nettype wire

[design/rfc_queue.sv]
// Job queue between front and back end.
`default_nettype none
module rfc_queue #(
  parameter int unsigned DEPTH = rfc_pkg::QueueDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rfc_pkg::cmd_t  push_cmd_i,
  input  wire logic           pop_i,
  output rfc_pkg::cmd_t       head_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  rfc_pkg::cmd_t slot_q [DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

[design/rfc_back.sv]
// Back end: expands queued jobs into result items behind an output register.
`default_nettype none
module rfc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rfc_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               kind_o,
  output logic [9:0]         index_o,
  output logic [7:0]         data_byte_o,
  output logic [2:0]         status_o,
  output logic [10:0]        out_len_o,
  output logic [15:0]        status_word_o,
  output logic               last_o
);

  logic        valid_q;
  logic        detail_step_q, detail_step_d;
  logic        load;
  logic        kind_q, kind_d;
  logic [9:0]  index_q, index_d;
  logic [7:0]  data_q, data_d;
  logic [2:0]  status_q, status_d;
  logic [10:0] len_q, len_d;
  logic [15:0] sw_q, sw_d;
  logic        last_q, last_d;

  assign load = (!valid_q || !out_stall_i) && !empty_i;

  always_comb begin
    kind_d        = 1'b1;
    index_d       = '0;
    data_d        = '0;
    status_d      = head_i.status;
    len_d         = head_i.out_len;
    sw_d          = head_i.sw;
    last_d        = 1'b1;
    pop_o         = load;
    detail_step_d = detail_step_q;
    case (head_i.op)
      rfc_pkg::CMD_WRITE: begin
        kind_d   = 1'b0;
        index_d  = head_i.index;
        data_d   = head_i.data;
        status_d = rfc_pkg::ST_OK;
        len_d    = '0;
        sw_d     = '0;
      end
      rfc_pkg::CMD_DETAIL: begin
        if (!detail_step_q) begin
          // first half: SW2 write to index 0, job stays queued
          kind_d   = 1'b0;
          data_d   = head_i.data;
          status_d = rfc_pkg::ST_OK;
          len_d    = '0;
          sw_d     = '0;
          last_d   = 1'b0;
          pop_o    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      detail_step_d = (head_i.op == rfc_pkg::CMD_DETAIL) && !detail_step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      detail_step_q <= 1'b0;
    end else begin
      detail_step_q <= detail_step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      index_q  <= index_d;
      data_q   <= data_d;
      status_q <= status_d;
      len_q    <= len_d;
      sw_q     <= sw_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign index_o       = index_q;
  assign data_byte_o   = data_q;
  assign status_o      = status_q;
  assign out_len_o     = len_q;
  assign status_word_o = sw_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

[design/response_frame_checker_with_status.sv]
// Top level of the response frame checker: config register, front, queue, back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | sink      | in_valid_i/in_stall_o | action_i, rx_byte_i
//   out     | source    | out_valid_o/out_stall_i | kind_o, index_o, data_byte_o,
//           |           |                      | status_o, out_len_o, status_word_o,
//           |           |                      | last_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (buffer capacity)
//
// One item is taken per cycle while the queue is not full. The front state machine
// updates its per-frame state in the cycle the item is accepted and pushes at
// most one job into a QUEUE_DEPTH-entry queue at the accepting edge; the back end
// loads each job from the queue head into the output register. A status-detail job
// yields two result items, the write and then the status item, so the back end
// pops one job per loaded result item except for that case.
// in_stall_o is high only while the queue is full; out_stall_i holds the output
// register and the queue absorbs the difference. Reset is asynchronous, active
// low, and leaves the frame state idle with capacity 1024. cfg_ready_o is always
// high.
`default_nettype none
module response_frame_checker_with_status #(
  parameter int unsigned BUFFER_DEPTH = rfc_pkg::BufferDepthDefault,
  parameter int unsigned QUEUE_DEPTH  = rfc_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  rx_byte_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [9:0]       index_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       status_o,
  output logic [10:0]      out_len_o,
  output logic [15:0]      status_word_o,
  output logic             last_o,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_data_i
);

  logic [10:0]   capacity_q;
  logic          accept;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  rfc_pkg::cmd_t push_cmd;
  rfc_pkg::cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  // Buffer capacity register; the user must write it only while the block is quiet (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= rfc_pkg::CapacityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Front: phase tracking, running XOR, length and status byte capture.
  rfc_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .capacity_i (capacity_q),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouples the two halves so an output stall does not stop intake at once.
  rfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Back: result formatting and output register.
  rfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .index_o       (index_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .out_len_o     (out_len_o),
    .status_word_o (status_word_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the response frame checker with status.
module tb;

  localparam int unsigned ItemsTarget  = 1500;    // counted items over the whole run
  localparam int unsigned QuietCycles  = 8;       // covers the two-stage result path
  localparam int unsigned DrainLimit   = 20000;   // cycles to wait for results to arrive
  localparam int unsigned TimeoutUnits = 40_000_000;
  localparam int unsigned ShownFaults  = 10;

  localparam logic ActStart   = 1'b0;
  localparam logic ActByte    = 1'b1;
  localparam logic KindWrite  = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    FR_IDLE, FR_LEN_HI, FR_LEN_LO, FR_PAYLOAD, FR_SW1, FR_SW2, FR_CHECK
  } frame_phase_e;

  typedef struct packed {
    logic        kind;
    logic [9:0]  index;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [10:0] out_len;
    logic [15:0] sw;
    logic        last;
  } frame_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        action_i    = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [10:0] cfg_data_i  = 11'd0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [9:0]  index_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic [10:0] out_len_o;
  logic [15:0] status_word_o;
  logic        last_o;
  logic        cfg_ready_o;

  response_frame_checker_with_status dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .index_o       (index_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .out_len_o     (out_len_o),
    .status_word_o (status_word_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Deframer state as predicted from the accepted items.
  frame_phase_e  fr_phase    = FR_IDLE;
  logic [7:0]    len_hi_q    = 8'h00;
  logic [15:0]   remaining_q = 16'd0;
  logic [10:0]   stored_q    = 11'd0;
  logic [7:0]    xor_q       = 8'h00;
  logic [7:0]    sw1_q       = 8'h00;
  logic [7:0]    sw2_q       = 8'h00;
  logic [10:0]   capacity_q  = rfc_pkg::CapacityReset;

  frame_result_t awaited_results[$];
  int unsigned   counted_items = 0;  // items that moved the frame state
  int unsigned   fault_count   = 0;
  bit            jitter_on     = 1'b0;

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= ShownFaults) $display("%s", msg);
  endfunction

  function automatic void queue_result(input logic kind, input logic [9:0] index,
                                       input logic [7:0] data,
                                       input rfc_pkg::status_e status,
                                       input logic [10:0] out_len, input logic [15:0] sw,
                                       input logic last);
    frame_result_t r;
    r = '{kind, index, data, status, out_len, sw, last};
    awaited_results.push_back(r);
  endfunction

  // Advance the deframer by one accepted item and queue what it must produce.
  function automatic void deframe_byte(input logic act, input logic [7:0] b);
    logic [15:0] len;
    logic [15:0] sw;
    int unsigned room;
    room = capacity_q;
    if (room > rfc_pkg::BufferDepthDefault) room = rfc_pkg::BufferDepthDefault;
    if (room > rfc_pkg::IndexSpan) room = rfc_pkg::IndexSpan;
    if (act == ActStart) begin
      // a start abandons whatever frame was open
      counted_items++;
      fr_phase    = FR_LEN_HI;
      len_hi_q    = 8'h00;
      remaining_q = 16'd0;
      stored_q    = 11'd0;
      xor_q       = 8'h00;
      sw1_q       = 8'h00;
      sw2_q       = 8'h00;
    end else begin
      if (fr_phase != FR_IDLE) counted_items++;
      case (fr_phase)
        FR_LEN_HI: begin
          len_hi_q = b;
          xor_q ^= b;
          fr_phase = FR_LEN_LO;
        end
        FR_LEN_LO: begin
          len = {len_hi_q, b};
          xor_q ^= b;
          if (len < 16'd2) begin
            fr_phase = FR_IDLE;
            queue_result(KindStatus, 10'd0, 8'h00, rfc_pkg::ST_LEN, 11'd0, 16'd0, 1'b1);
          end else begin
            remaining_q = len - 16'd2;
            fr_phase = (remaining_q != 16'd0) ? FR_PAYLOAD : FR_SW1;
          end
        end
        FR_PAYLOAD: begin
          xor_q ^= b;
          // bytes past the buffer still feed the checksum
          if (stored_q < room) begin
            queue_result(KindWrite, stored_q[9:0], b, rfc_pkg::ST_OK, 11'd0, 16'd0, 1'b1);
            stored_q++;
          end
          remaining_q--;
          if (remaining_q == 16'd0) fr_phase = FR_SW1;
        end
        FR_SW1: begin
          sw1_q = b;
          xor_q ^= b;
          fr_phase = FR_SW2;
        end
        FR_SW2: begin
          sw2_q = b;
          xor_q ^= b;
          fr_phase = FR_CHECK;
        end
        FR_CHECK: begin
          sw = {sw1_q, sw2_q};
          fr_phase = FR_IDLE;
          if (xor_q != b) begin
            queue_result(KindStatus, 10'd0, 8'h00, rfc_pkg::ST_CSUM, stored_q, 16'd0,
                         1'b1);
          end else if (sw1_q == rfc_pkg::Sw1Ok && sw2_q == rfc_pkg::Sw2Ok) begin
            queue_result(KindStatus, 10'd0, 8'h00, rfc_pkg::ST_OK, stored_q, sw, 1'b1);
          end else if (sw1_q == rfc_pkg::Sw1Retry || sw1_q == rfc_pkg::Sw1Ok) begin
            // detail byte lands at index 0 regardless of capacity
            queue_result(KindWrite, 10'd0, sw2_q, rfc_pkg::ST_OK, 11'd0, 16'd0, 1'b0);
            queue_result(KindStatus, 10'd0, 8'h00, rfc_pkg::ST_DETAIL, 11'd1, sw, 1'b1);
          end else begin
            queue_result(KindStatus, 10'd0, 8'h00, rfc_pkg::ST_SW, stored_q, sw, 1'b1);
          end
        end
        default: fr_phase = FR_IDLE;
      endcase
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic act, input logic [7:0] b);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      action_i   <= 1'($urandom);
      rx_byte_i  <= 8'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(act, b);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned n_payload, input logic [7:0] sw1,
                            input logic [7:0] sw2, input bit good_sum);
    logic [15:0] len;
    logic [7:0]  sum;
    logic [7:0]  b;
    len = 16'(n_payload + 2);
    sum = len[15:8] ^ len[7:0];
    send_item(ActStart, 8'($urandom));
    send_item(ActByte, len[15:8]);
    send_item(ActByte, len[7:0]);
    repeat (n_payload) begin
      b = 8'($urandom);
      sum ^= b;
      send_item(ActByte, b);
    end
    send_item(ActByte, sw1);
    send_item(ActByte, sw2);
    sum ^= sw1 ^ sw2;
    if (!good_sum) sum = sum ^ (8'd1 << $urandom_range(0, 7));
    send_item(ActByte, sum);
  endtask

  // Stop sending and wait until everything predicted has come out.
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", awaited_results.size()));
      awaited_results.delete();
    end
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [10:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stray bytes, short lengths and an abandoned frame.
  task automatic test_frame_edges();
    send_item(ActByte, 8'hFF);
    send_item(ActStart, 8'hFF);
    send_item(ActByte, 8'h00);
    send_item(ActByte, 8'h00);
    send_item(ActStart, 8'h00);
    send_item(ActByte, 8'h00);
    send_item(ActByte, 8'h01);
    send_item(ActStart, 8'h5A);
    send_item(ActByte, 8'h12);
  endtask

  // Frames for each end-of-frame status outcome; the detail outcome gets two frames.
  task automatic test_status_words();
    send_frame(1, rfc_pkg::Sw1Ok, rfc_pkg::Sw2Ok, 1'b1);
    send_frame(0, rfc_pkg::Sw1Retry, 8'hFF, 1'b1);
    send_frame(0, rfc_pkg::Sw1Ok, 8'h12, 1'b1);
    send_frame(0, 8'h6A, 8'h82, 1'b1);
    send_frame(0, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(11'd0);
    send_frame(3, rfc_pkg::Sw1Retry, 8'h5A, 1'b1);
    write_capacity(11'd1);
    send_frame(4, rfc_pkg::Sw1Ok, rfc_pkg::Sw2Ok, 1'b1);
    // above the buffer depth: clamps to 1024, last index 1023
    write_capacity(11'h7FF);
    send_frame(1030, rfc_pkg::Sw1Ok, rfc_pkg::Sw2Ok, 1'b1);
    write_capacity(rfc_pkg::CapacityReset);
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned phase_end;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  s1;
    logic [7:0]  s2;
    goal = ItemsTarget;
    while (counted_items < goal) begin
      case ($urandom_range(0, 5))
        0:       write_capacity(11'd0);
        1:       write_capacity(11'($urandom_range(1, 4)));
        2:       write_capacity(11'($urandom_range(5, 40)));
        3:       write_capacity(rfc_pkg::CapacityReset);
        4:       write_capacity(11'h7FF);
        default: write_capacity(11'($urandom_range(0, 2047)));
      endcase
      // the tail of the run goes without gaps or stalls
      jitter_on = (goal - counted_items > 300) && ($urandom_range(0, 3) != 0);
      phase_end = counted_items + $urandom_range(100, 200);
      while (counted_items < phase_end && counted_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
          case ($urandom_range(0, 3))
            0: begin
              s1 = rfc_pkg::Sw1Ok;
              s2 = rfc_pkg::Sw2Ok;
            end
            1: begin
              s1 = rfc_pkg::Sw1Retry;
              s2 = 8'($urandom);
            end
            2: begin
              s1 = rfc_pkg::Sw1Ok;
              s2 = 8'($urandom);
            end
            default: begin
              s1 = 8'($urandom);
              s2 = 8'($urandom);
            end
          endcase
          send_frame(n, s1, s2, $urandom_range(0, 7) != 0);
        end else if (pick < 82) begin
          send_item(ActStart, 8'($urandom));
          send_item(ActByte, 8'h00);
          send_item(ActByte, 8'($urandom_range(0, 1)));
        end else if (pick < 90) begin
          // truncated frame, left for the next start to abandon
          send_item(ActStart, 8'($urandom));
          repeat ($urandom_range(0, 8)) send_item(ActByte, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item($urandom_range(0, 3) != 0, 8'($urandom));
          end
        end
      end
    end
    jitter_on = 1'b0;
  endtask

  // Result stall in short random bursts while jitter is on.
  initial begin
    forever begin
      @(negedge clk_i);
      if (jitter_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {kind_o, index_o, data_byte_o, status_o, out_len_o, status_word_o, last_o};
      if (awaited_results.size() == 0) begin
        log_fault($sformatf("unexpected result kind=%0d idx=%0d data=%02h st=%0d",
                            got.kind, got.index, got.data, got.status));
      end else begin
        want = awaited_results.pop_front();
        if (got.kind !== want.kind || got.index !== want.index ||
            got.data !== want.data || got.status !== want.status ||
            got.out_len !== want.out_len || got.sw !== want.sw ||
            got.last !== want.last) begin
          log_fault($sformatf(
            "mismatch want k=%0d i=%0d d=%02h s=%0d l=%0d sw=%04h e=%0d",
            want.kind, want.index, want.data, want.status, want.out_len, want.sw,
            want.last));
          if (fault_count <= ShownFaults) begin
            $display("         got  k=%0d i=%0d d=%02h s=%0d l=%0d sw=%04h e=%0d",
                     got.kind, got.index, got.data, got.status, got.out_len, got.sw,
                     got.last);
          end
        end
      end
    end
  end

  initial begin
    #(TimeoutUnits);
    $display("tb: errors");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_frame_edges();
    jitter_on = 1'b1;
    test_status_words();
    test_capacity_limits();
    test_random_traffic();
    settle_block();
    if (fault_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
